[src/assert_macros.svh]
// Assertion macros shared by the timer channel modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/datc_pkg.sv]
// Types, constants and helpers for the daily alarm timer channels.
package datc_pkg;

  // Field widths
  localparam int OP_W      = 4;
  localparam int CH_FW     = 2;
  localparam int TIME_W    = 32;
  localparam int MINS_W    = 8;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // Channel set
  localparam int NUM_CHANNELS = 3;
  localparam int LED_CHANNEL  = 2;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Result buffer for one tick
  localparam int MAX_RESULTS = 3;
  localparam int RI_W        = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int RN_W        = $clog2(MAX_RESULTS + 1);

  // Time constants
  localparam logic [TIME_W-1:0] DAY_SECS     = 32'd86400;
  localparam logic [TIME_W-1:0] OFF_SLACK    = 32'd30;
  localparam logic [TIME_W-1:0] SECS_PER_MIN = 32'd60;
  localparam logic [TIME_W-1:0] SECS_PER_HR  = 32'd3600;
  localparam logic [HOUR_W-1:0] HOUR_MAX     = 5'd23;
  localparam logic [MIN_W-1:0]  MINUTE_MAX   = 6'd59;
  localparam int REM_W = $clog2(DAY_SECS);

  // Configuration reset values
  localparam logic [CFG_W-1:0] RUN_MAX_RST     = 8'd120;
  localparam logic [CFG_W-1:0] RUN_MIN_RST     = 8'd1;
  localparam logic [CFG_W-1:0] LED_RUN_MIN_RST = 8'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_MAX     = 2'd0,
    CFG_RUN_MIN     = 2'd1,
    CFG_LED_RUN_MIN = 2'd2
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 4'd0,
    OP_ON_FOR     = 4'd1,
    OP_ON_DEFAULT = 4'd2,
    OP_OFF_NOW    = 4'd3,
    OP_OFF_AFTER  = 4'd4,
    OP_ARM        = 4'd5,
    OP_DISARM     = 4'd6,
    OP_REPEAT     = 4'd7,
    OP_ONCE       = 4'd8,
    OP_SET_ALARM  = 4'd9
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 2'd0,
    ACT_ON        = 2'd1,
    ACT_OFF       = 2'd2,
    ACT_FADE_DOWN = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_CMD,
    ST_OFF,
    ST_FIRE_LO,
    ST_FIRE_HI,
    ST_BUILD,
    ST_SETTLE,
    ST_PUSH,
    ST_OUT
  } state_t;

  // One result item
  typedef struct packed {
    logic [CH_FW-1:0]  ch;
    logic              on;
    act_t              act;
    logic [MINS_W-1:0] mins;
    logic              acc;
  } res_t;

  // Minutes to seconds
  function automatic logic [TIME_W-1:0] mins_to_secs(input logic [MINS_W-1:0] m);
    return TIME_W'(m) * SECS_PER_MIN;
  endfunction

  // Seconds from midnight for an hour and minute
  function automatic logic [TIME_W-1:0] time_of_day(input logic [HOUR_W-1:0] h,
                                                    input logic [MIN_W-1:0] m);
    return TIME_W'(h) * SECS_PER_HR + TIME_W'(m) * SECS_PER_MIN;
  endfunction

endpackage

[src/datc_daymod.sv]
// Remainder unit: seconds into the UTC day by reciprocal multiplication.
`include "assert_macros.svh"

module datc_daymod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [datc_pkg::TIME_W-1:0]   value,
  output logic                          done,
  output logic [datc_pkg::REM_W-1:0]    rem
);
  import datc_pkg::*;

  // value / 86400 = (value >> 7) / 675; the rounded-up reciprocal of 675 at
  // 2^35 is exact for every 25-bit dividend
  localparam int               DIV_SHIFT = 7;
  localparam int               X_W       = TIME_W - DIV_SHIFT;
  localparam int               RCP_SHIFT = 35;
  localparam int               RCP_W     = 26;
  localparam logic [RCP_W-1:0] RCP       = 26'd50903317;
  localparam int               PROD_W    = X_W + RCP_W;
  localparam int               Q_W       = PROD_W - RCP_SHIFT;

  logic              mul_r;
  logic              sub_r;
  logic              done_r;
  logic [TIME_W-1:0] val_r;
  logic [PROD_W-1:0] prod_r;
  logic [REM_W-1:0]  rem_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [Q_W-1:0]    quot;
  logic [TIME_W-1:0] day_base;
  logic [REM_W-1:0]  rem_nxt;

  // Scale by the reciprocal, then take back whole days
  always_comb begin
    prod_nxt = PROD_W'(val_r[TIME_W-1:DIV_SHIFT]) * PROD_W'(RCP);
    quot     = prod_r[PROD_W-1:RCP_SHIFT];
    day_base = TIME_W'(quot) * DAY_SECS;
    rem_nxt  = REM_W'(val_r - day_base);
  end

  // Hold the value and advance the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
      val_r  <= '0;
      prod_r <= '0;
      rem_r  <= '0;
    end else begin
      mul_r  <= start;
      sub_r  <= mul_r;
      done_r <= sub_r;
      if (start) val_r  <= value;
      if (mul_r) prod_r <= prod_nxt;
      if (sub_r) rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `ASSERT_IMPL(rem_in_range, done_r, rem_r < REM_W'(DAY_SECS))
  `ASSERT_IMPL(base_below_value, sub_r, day_base <= val_r)
  `ASSERT_NEXT(start_then_mul, start, mul_r)

endmodule

[src/daily_alarm_timer_channels_top.sv]
// Top level of the daily alarm timer channels: sequencer, channel state and result buffer.
`include "assert_macros.svh"

// Three channels (heater, water, fading LED), each with an auto-off time and a
// daily alarm. An item is taken in an idle cycle; a shared remainder unit then
// finds the start of the UTC day of in_now by a reciprocal multiplication.
// A command then yields one result and, where it changes the alarm, rebuilds it. A tick
// visits the channels in order, through ST_OFF, ST_FIRE_LO and ST_FIRE_HI, with
// ST_BUILD and ST_SETTLE for one that fires, then ST_PUSH, and then delivers up
// to three results, one per cycle while out_stall is low; a tick where nothing
// acted yields no result.
// in_stall stays high from acceptance until the last result has been taken.
module daily_alarm_timer_channels_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [datc_pkg::OP_W-1:0]       in_opcode,
  input  logic [datc_pkg::CH_FW-1:0]      in_channel,
  input  logic [datc_pkg::TIME_W-1:0]     in_now,
  input  logic [datc_pkg::MINS_W-1:0]     in_duration_mins,
  input  logic [datc_pkg::HOUR_W-1:0]     in_alarm_hour_in,
  input  logic [datc_pkg::MIN_W-1:0]      in_alarm_minute_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [datc_pkg::CH_FW-1:0]      out_channel,
  output logic                            out_is_on,
  output logic [datc_pkg::ACT_W-1:0]      out_drive_action,
  output logic [datc_pkg::MINS_W-1:0]     out_action_mins,
  output logic                            out_accepted,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [datc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [datc_pkg::CFG_W-1:0]      cfg_wdata
);
  import datc_pkg::*;

  // Sequencer
  state_t state_r, state_nxt;

  // Configuration
  logic [CFG_W-1:0] run_max_r;
  logic [CFG_W-1:0] run_min_r;
  logic [CFG_W-1:0] led_run_min_r;

  // Channel state
  logic              chan_on_r   [NUM_CHANNELS];
  logic [TIME_W-1:0] off_time_r  [NUM_CHANNELS];
  logic [TIME_W-1:0] alarm_time_r[NUM_CHANNELS];
  logic              armed_r     [NUM_CHANNELS];
  logic              repeats_r   [NUM_CHANNELS];
  logic [HOUR_W-1:0] hour_r      [NUM_CHANNELS];
  logic [MIN_W-1:0]  minute_r    [NUM_CHANNELS];
  logic [MINS_W-1:0] run_r       [NUM_CHANNELS];

  // Item being worked on
  logic [OP_W-1:0]   op_r;
  logic [CH_FW-1:0]  ch_r;
  logic [TIME_W-1:0] now_r;
  logic [MINS_W-1:0] dur_r;
  logic [HOUR_W-1:0] h_r;
  logic [MIN_W-1:0]  m_r;
  logic [CH_W-1:0]   cidx_r;
  logic [TIME_W-1:0] dstart_r;
  logic [TIME_W-1:0] t_r;
  logic              lo_ok_r;
  act_t              act_r;
  logic [MINS_W-1:0] am_r;

  // Result buffer
  res_t              buf_r[MAX_RESULTS];
  logic [RN_W-1:0]   nres_r;
  logic [RI_W-1:0]   oidx_r;

  // Remainder unit
  logic              mod_done;
  logic [REM_W-1:0]  mod_rem;

  logic              in_acc;
  logic              out_acc;
  logic              ch_ok;
  logic              is_led;
  logic              time_ok;
  logic              cur_on;
  logic [MINS_W-1:0] cur_run;
  logic              off_hit;
  logic              fire;
  logic              cmd_build;
  logic              do_push;
  logic [RN_W-1:0]   push_cnt;
  logic              last_ch;
  logic [MINS_W-1:0] run_hi;
  logic [MINS_W-1:0] run_lo;
  logic [MINS_W-1:0] run_cl;
  logic [HOUR_W-1:0] h_cl;
  logic [MIN_W-1:0]  m_cl;
  logic [MINS_W-1:0] cmd_d;
  res_t              cmd_res;
  res_t              out_res;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  datc_daymod u_daymod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .value (in_now),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Current channel view and decode
  always_comb begin
    ch_ok   = (32'(ch_r) < NUM_CHANNELS);
    is_led  = (32'(cidx_r) == LED_CHANNEL);
    time_ok = (h_r <= HOUR_MAX) && (m_r <= MINUTE_MAX);
    cur_on  = chan_on_r[cidx_r];
    cur_run = run_r[cidx_r];
    off_hit = cur_on && (now_r >= off_time_r[cidx_r] - OFF_SLACK);
    fire    = lo_ok_r && (now_r < alarm_time_r[cidx_r] + mins_to_secs(cur_run));
    do_push = (act_r != ACT_NONE) && (32'(nres_r) < MAX_RESULTS);
    push_cnt = nres_r + RN_W'(do_push);
    last_ch = (32'(cidx_r) == NUM_CHANNELS - 1);
    // Clamp run minutes: maximum first, then the channel minimum wins
    run_hi  = (cur_run > run_max_r) ? run_max_r : cur_run;
    run_lo  = is_led ? led_run_min_r : run_min_r;
    run_cl  = (run_hi < run_lo) ? run_lo : run_hi;
    h_cl    = (hour_r[cidx_r] > HOUR_MAX) ? HOUR_MAX : hour_r[cidx_r];
    m_cl    = (minute_r[cidx_r] > MINUTE_MAX) ? MINUTE_MAX : minute_r[cidx_r];
  end

  // Command result and whether the alarm must be rebuilt
  always_comb begin
    cmd_d     = (op_r == OP_ON_FOR) ? dur_r : cur_run;
    cmd_build = 1'b0;
    cmd_res   = '{ch: ch_r, on: 1'b0, act: ACT_NONE, mins: '0, acc: 1'b0};
    if (ch_ok) begin
      cmd_res.on = cur_on;
      case (op_r)
        OP_ON_FOR, OP_ON_DEFAULT: begin
          cmd_res = '{ch: ch_r, on: 1'b1, act: ACT_ON, mins: cmd_d, acc: 1'b1};
        end
        OP_OFF_NOW: begin
          cmd_res = '{ch: ch_r, on: 1'b0, act: ACT_OFF,
                      mins: (is_led ? cur_run : '0), acc: 1'b1};
        end
        OP_OFF_AFTER: begin
          cmd_res = '{ch: ch_r, on: 1'b1, act: (is_led ? ACT_FADE_DOWN : ACT_ON),
                      mins: dur_r, acc: 1'b1};
        end
        OP_ARM, OP_DISARM, OP_REPEAT, OP_ONCE: begin
          cmd_res.acc = 1'b1;
          cmd_build   = 1'b1;
        end
        OP_SET_ALARM: begin
          cmd_res.acc = time_ok;
          cmd_build   = time_ok;
        end
        default: begin
          cmd_res.acc = 1'b0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_MOD;
      ST_MOD:     if (mod_done) state_nxt = (op_r == OP_TICK) ? ST_OFF : ST_CMD;
      ST_CMD:     state_nxt = cmd_build ? ST_BUILD : ST_OUT;
      ST_OFF:     state_nxt = ST_FIRE_LO;
      ST_FIRE_LO: state_nxt = ST_FIRE_HI;
      ST_FIRE_HI: state_nxt = fire ? ST_BUILD : ST_PUSH;
      ST_BUILD:   state_nxt = ST_SETTLE;
      ST_SETTLE:  state_nxt = (op_r == OP_TICK) ? ST_PUSH : ST_OUT;
      ST_PUSH: begin
        if (!last_ch) begin
          state_nxt = ST_OFF;
        end else begin
          state_nxt = (push_cnt != '0) ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT:     if (out_acc && out_last) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_max_r     <= RUN_MAX_RST;
      run_min_r     <= RUN_MIN_RST;
      led_run_min_r <= LED_RUN_MIN_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_on_r[i]    <= 1'b0;
        off_time_r[i]   <= '0;
        alarm_time_r[i] <= '0;
        armed_r[i]      <= 1'b0;
        repeats_r[i]    <= 1'b0;
        hour_r[i]       <= '0;
        minute_r[i]     <= '0;
        run_r[i]        <= RUN_MIN_RST;
      end
      nres_r <= '0;
      oidx_r <= '0;
    end else begin
      // Take configuration writes at any time
      if (cfg_we) begin
        case (cfg_index)
          CFG_RUN_MAX:     run_max_r     <= cfg_wdata;
          CFG_RUN_MIN:     run_min_r     <= cfg_wdata;
          CFG_LED_RUN_MIN: led_run_min_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r   <= in_opcode;
            ch_r   <= in_channel;
            now_r  <= in_now;
            dur_r  <= in_duration_mins;
            h_r    <= in_alarm_hour_in;
            m_r    <= in_alarm_minute_in;
            cidx_r <= (in_opcode == OP_TICK) ? '0 : CH_W'(in_channel);
            nres_r <= '0;
            oidx_r <= '0;
          end
        end

        ST_MOD: begin
          if (mod_done) dstart_r <= now_r - TIME_W'(mod_rem);
        end

        // Apply a command to its channel and hold its one result
        ST_CMD: begin
          buf_r[0] <= cmd_res;
          nres_r   <= RN_W'(1);
          if (ch_ok) begin
            case (op_r)
              OP_ON_FOR, OP_ON_DEFAULT: begin
                chan_on_r[cidx_r]  <= 1'b1;
                off_time_r[cidx_r] <= now_r + mins_to_secs(cmd_d);
              end
              OP_OFF_NOW:   chan_on_r[cidx_r] <= 1'b0;
              OP_OFF_AFTER: begin
                chan_on_r[cidx_r]  <= 1'b1;
                off_time_r[cidx_r] <= now_r + mins_to_secs(dur_r);
              end
              OP_ARM:    armed_r[cidx_r]   <= 1'b1;
              OP_DISARM: armed_r[cidx_r]   <= 1'b0;
              OP_REPEAT: repeats_r[cidx_r] <= 1'b1;
              OP_ONCE:   repeats_r[cidx_r] <= 1'b0;
              OP_SET_ALARM: begin
                if (time_ok) begin
                  armed_r[cidx_r]  <= 1'b1;
                  hour_r[cidx_r]   <= h_r;
                  minute_r[cidx_r] <= m_r;
                  if (dur_r != '0) run_r[cidx_r] <= dur_r;
                end
              end
              default: ;
            endcase
          end
        end

        // Switch off a channel near its off time
        ST_OFF: begin
          if (off_hit) begin
            chan_on_r[cidx_r] <= 1'b0;
            act_r <= ACT_OFF;
            am_r  <= is_led ? cur_run : '0;
          end else begin
            act_r <= ACT_NONE;
            am_r  <= '0;
          end
        end

        // Lower edge of the alarm window
        ST_FIRE_LO: begin
          lo_ok_r <= armed_r[cidx_r] &&
                     (now_r > alarm_time_r[cidx_r] - OFF_SLACK);
        end

        // Upper edge; on a fire re-arm as the repeat flag says
        ST_FIRE_HI: begin
          if (fire) begin
            armed_r[cidx_r] <= repeats_r[cidx_r];
            act_r <= ACT_ON;
          end
        end

        // Clamp the alarm fields and form today's alarm time
        ST_BUILD: begin
          run_r[cidx_r]    <= run_cl;
          hour_r[cidx_r]   <= h_cl;
          minute_r[cidx_r] <= m_cl;
          t_r <= dstart_r + time_of_day(h_cl, m_cl);
        end

        // Move the alarm to tomorrow if due; start the run after a fire
        ST_SETTLE: begin
          alarm_time_r[cidx_r] <= (t_r <= now_r) ? t_r + DAY_SECS : t_r;
          if (op_r == OP_TICK) begin
            chan_on_r[cidx_r]  <= 1'b1;
            off_time_r[cidx_r] <= now_r + mins_to_secs(cur_run);
            am_r <= cur_run;
          end
        end

        // Record an acting channel, then advance
        ST_PUSH: begin
          if (do_push) begin
            buf_r[nres_r[RI_W-1:0]] <= '{ch: CH_FW'(cidx_r), on: cur_on, act: act_r,
                                          mins: am_r, acc: 1'b1};
          end
          nres_r <= push_cnt;
          if (!last_ch) cidx_r <= cidx_r + CH_W'(1);
        end

        // Deliver buffered results in order
        ST_OUT: begin
          if (out_acc) oidx_r <= out_last ? '0 : oidx_r + RI_W'(1);
        end

        default: ;
      endcase
    end
  end

  // Ports
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_res   = buf_r[oidx_r];
  assign out_last  = (32'(oidx_r) + 1 == 32'(nres_r));
  assign out_channel      = out_res.ch;
  assign out_is_on        = out_res.on;
  assign out_drive_action = out_res.act;
  assign out_action_mins  = out_res.mins;
  assign out_accepted     = out_res.acc;

  `ASSERT_IMPL(out_blocks_in, out_valid, in_stall)
  `ASSERT_IMPL(out_has_result, out_valid, nres_r != '0)
  `ASSERT_NEXT(accept_starts_mod, in_valid && !in_stall, state_r == ST_MOD)

endmodule

[bench/tb_daily_alarm_timer_channels_top.sv]
// Testbench for the daily alarm timer channels: scoreboard class, stimulus and checks.
module tb_daily_alarm_timer_channels_top;
  import datc_pkg::*;

  // One input item as driven on the in_ ports
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CH_FW-1:0]  ch;
    logic [TIME_W-1:0] now;
    logic [MINS_W-1:0] dur;
    logic [HOUR_W-1:0] hr;
    logic [MIN_W-1:0]  mn;
  } cmd_item_t;

  // One result item as seen on the out_ ports
  typedef struct packed {
    logic [CH_FW-1:0]  ch;
    logic              on;
    logic [ACT_W-1:0]  act;
    logic [MINS_W-1:0] mins;
    logic              acc;
    logic              last;
  } report_t;

  // Channel state mirror and queue of channel reports still due
  class channel_scoreboard;
    logic [CFG_W-1:0]  run_max, run_min, led_run_min;
    logic              chan_on  [NUM_CHANNELS];
    logic [TIME_W-1:0] off_time [NUM_CHANNELS];
    logic [TIME_W-1:0] alarm_at [NUM_CHANNELS];
    logic              armed    [NUM_CHANNELS];
    logic              repeats  [NUM_CHANNELS];
    logic [HOUR_W-1:0] hour     [NUM_CHANNELS];
    logic [MIN_W-1:0]  minute   [NUM_CHANNELS];
    logic [MINS_W-1:0] run_mins [NUM_CHANNELS];
    report_t           due_reports[$];
    int                fails;

    function new();
      int c;
      run_max     = RUN_MAX_RST;
      run_min     = RUN_MIN_RST;
      led_run_min = LED_RUN_MIN_RST;
      fails       = 0;
      for (c = 0; c < NUM_CHANNELS; c++) begin
        chan_on[c]  = 1'b0;
        off_time[c] = '0;
        alarm_at[c] = '0;
        armed[c]    = 1'b0;
        repeats[c]  = 1'b0;
        hour[c]     = '0;
        minute[c]   = '0;
        run_mins[c] = RUN_MIN_RST;
      end
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_RUN_MAX:     run_max = v;
        CFG_RUN_MIN:     run_min = v;
        CFG_LED_RUN_MIN: led_run_min = v;
        default: ;
      endcase
    endfunction

    // Clamp run minutes (minimum wins) and place the alarm at its next occurrence
    function void reschedule(int c, logic [TIME_W-1:0] now);
      logic [CFG_W-1:0]  lo;
      logic [TIME_W-1:0] t;
      lo = (c == LED_CHANNEL) ? led_run_min : run_min;
      if (run_mins[c] > run_max) run_mins[c] = run_max;
      if (run_mins[c] < lo) run_mins[c] = lo;
      t = now - (now % DAY_SECS);
      t = t + TIME_W'(hour[c]) * SECS_PER_HR + TIME_W'(minute[c]) * SECS_PER_MIN;
      if (t <= now) t = t + DAY_SECS;
      alarm_at[c] = t;
    endfunction

    function void add(int c, logic [ACT_W-1:0] act, logic [MINS_W-1:0] mins,
                      logic acc, logic last);
      report_t r;
      r.ch   = CH_FW'(c);
      r.on   = (c < NUM_CHANNELS) ? chan_on[c] : 1'b0;
      r.act  = act;
      r.mins = mins;
      r.acc  = acc;
      r.last = last;
      due_reports.push_back(r);
    endfunction

    // Advance the mirror by one accepted item and queue its reports
    function void note_item(cmd_item_t it);
      int                i, n, c;
      int                hit_ch   [MAX_RESULTS];
      logic [ACT_W-1:0]  hit_act  [MAX_RESULTS];
      logic [MINS_W-1:0] hit_mins [MAX_RESULTS];
      logic [ACT_W-1:0]  act;
      logic [MINS_W-1:0] mins;
      logic [MINS_W-1:0] d;
      if (it.op == OP_TICK) begin
        n = 0;
        for (i = 0; i < NUM_CHANNELS; i++) begin
          act  = ACT_NONE;
          mins = '0;
          // auto-off within the slack window
          if (chan_on[i] && it.now >= off_time[i] - OFF_SLACK) begin
            chan_on[i] = 1'b0;
            act  = ACT_OFF;
            mins = (i == LED_CHANNEL) ? run_mins[i] : '0;
          end
          // alarm fires inside its window
          if (armed[i] && it.now > alarm_at[i] - OFF_SLACK &&
              it.now < alarm_at[i] + TIME_W'(run_mins[i]) * SECS_PER_MIN) begin
            alarm_at[i] = alarm_at[i] + DAY_SECS;
            armed[i]    = repeats[i];
            reschedule(i, it.now);
            chan_on[i]  = 1'b1;
            off_time[i] = it.now + TIME_W'(run_mins[i]) * SECS_PER_MIN;
            act  = ACT_ON;
            mins = run_mins[i];
          end
          if (act != ACT_NONE && n < MAX_RESULTS) begin
            hit_ch[n]   = i;
            hit_act[n]  = act;
            hit_mins[n] = mins;
            n++;
          end
        end
        for (i = 0; i < n; i++)
          add(hit_ch[i], hit_act[i], hit_mins[i], 1'b1, i == n - 1);
        return;
      end
      c = it.ch;
      // drop bad channels and unknown opcodes
      if (c >= NUM_CHANNELS || it.op > OP_SET_ALARM) begin
        add(c, ACT_NONE, '0, 1'b0, 1'b1);
        return;
      end
      case (it.op)
        OP_ON_FOR, OP_ON_DEFAULT: begin
          d = (it.op == OP_ON_FOR) ? it.dur : run_mins[c];
          chan_on[c]  = 1'b1;
          off_time[c] = it.now + TIME_W'(d) * SECS_PER_MIN;
          add(c, ACT_ON, d, 1'b1, 1'b1);
          return;
        end
        OP_OFF_NOW: begin
          chan_on[c] = 1'b0;
          add(c, ACT_OFF, (c == LED_CHANNEL) ? run_mins[c] : '0, 1'b1, 1'b1);
          return;
        end
        OP_OFF_AFTER: begin
          chan_on[c]  = 1'b1;
          off_time[c] = it.now + TIME_W'(it.dur) * SECS_PER_MIN;
          add(c, (c == LED_CHANNEL) ? ACT_FADE_DOWN : ACT_ON, it.dur, 1'b1, 1'b1);
          return;
        end
        OP_ARM:    armed[c] = 1'b1;
        OP_DISARM: armed[c] = 1'b0;
        OP_REPEAT: repeats[c] = 1'b1;
        OP_ONCE:   repeats[c] = 1'b0;
        default: begin
          if (it.hr > HOUR_MAX || it.mn > MINUTE_MAX) begin
            add(c, ACT_NONE, '0, 1'b0, 1'b1);
            return;
          end
          armed[c]  = 1'b1;
          hour[c]   = it.hr;
          minute[c] = it.mn;
          if (it.dur != 0) run_mins[c] = it.dur;
        end
      endcase
      reschedule(c, it.now);
      add(c, ACT_NONE, '0, 1'b1, 1'b1);
    endfunction

    function void complain(string what, report_t exp, report_t got);
      fails++;
      if (fails <= 10) begin
        $display("mismatch (%s): exp ch=%0d on=%0b act=%0d mins=%0d acc=%0b last=%0b",
                 what, exp.ch, exp.on, exp.act, exp.mins, exp.acc, exp.last);
        $display("  got ch=%0d on=%0b act=%0d mins=%0d acc=%0b last=%0b",
                 got.ch, got.on, got.act, got.mins, got.acc, got.last);
      end
    endfunction

    // Compare one delivered report with the oldest one due
    function void check_result(report_t got);
      report_t exp;
      if (due_reports.size() == 0) begin
        complain("nothing due", '0, got);
        return;
      end
      exp = due_reports.pop_front();
      if (got.ch !== exp.ch || got.on !== exp.on || got.act !== exp.act ||
          got.mins !== exp.mins || got.acc !== exp.acc || got.last !== exp.last)
        complain("field", exp, got);
    endfunction

    function void final_check();
      if (due_reports.size() != 0) begin
        fails += due_reports.size();
        $display("%0d reports never arrived", due_reports.size());
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [CH_FW-1:0]     in_channel = '0;
  logic [TIME_W-1:0]    in_now = '0;
  logic [MINS_W-1:0]    in_duration_mins = '0;
  logic [HOUR_W-1:0]    in_alarm_hour_in = '0;
  logic [MIN_W-1:0]     in_alarm_minute_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CH_FW-1:0]     out_channel;
  logic                 out_is_on;
  logic [ACT_W-1:0]     out_drive_action;
  logic [MINS_W-1:0]    out_action_mins;
  logic                 out_accepted;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  channel_scoreboard board;
  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;
  logic [TIME_W-1:0] clock_s = 32'd1000;

  daily_alarm_timer_channels_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_channel(in_channel), .in_now(in_now),
    .in_duration_mins(in_duration_mins), .in_alarm_hour_in(in_alarm_hour_in),
    .in_alarm_minute_in(in_alarm_minute_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel(out_channel), .out_is_on(out_is_on),
    .out_drive_action(out_drive_action), .out_action_mins(out_action_mins),
    .out_accepted(out_accepted), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Check every report taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_channel, out_is_on, out_drive_action, out_action_mins,
                          out_accepted, out_last});
  end

  function automatic cmd_item_t mk(logic [OP_W-1:0] op, int ch, logic [TIME_W-1:0] now,
                                   int dur, int hr, int mn);
    cmd_item_t it;
    it.op  = op;
    it.ch  = CH_FW'(ch);
    it.now = now;
    it.dur = MINS_W'(dur);
    it.hr  = HOUR_W'(hr);
    it.mn  = MIN_W'(mn);
    return it;
  endfunction

  // Mostly ticks on a running clock, alarms set just ahead, short runs, some noise
  function automatic cmd_item_t rand_item();
    cmd_item_t         it;
    int                pick;
    logic [TIME_W-1:0] target;
    pick = $urandom_range(99);
    it = mk(OP_TICK, $urandom_range(3), clock_s, $urandom_range(255),
            $urandom_range(31), $urandom_range(63));
    if (pick < 48) begin
      case ($urandom_range(19))
        0:       clock_s = $urandom;
        1, 2:    clock_s = clock_s + DAY_SECS - $urandom_range(600);
        default: clock_s = clock_s + $urandom_range(1, 200);
      endcase
      it.now = clock_s;
    end else if (pick < 62) begin
      it.op = OP_SET_ALARM;
      it.ch = CH_FW'($urandom_range(2));
      target = clock_s % DAY_SECS + $urandom_range(900);
      if ($urandom_range(5) != 0) begin
        it.hr = HOUR_W'((target / SECS_PER_HR) % 24);
        it.mn = MIN_W'((target / SECS_PER_MIN) % 60);
        if ($urandom_range(4) != 0) it.dur = MINS_W'($urandom_range(8));
      end
    end else if (pick < 72) begin
      it.op = $urandom_range(1) ? OP_ON_FOR : OP_OFF_AFTER;
      it.ch = CH_FW'($urandom_range(2));
      if ($urandom_range(4) != 0) it.dur = MINS_W'($urandom_range(4));
    end else if (pick < 82) begin
      it.op = OP_ARM + OP_W'($urandom_range(3));
      it.ch = CH_FW'($urandom_range(2));
    end else if (pick < 90) begin
      it.op = $urandom_range(1) ? OP_ON_DEFAULT : OP_OFF_NOW;
      it.ch = CH_FW'($urandom_range(2));
    end else if (pick < 95) begin
      it.op = OP_W'($urandom_range(1, 15));
      it.ch = CH_FW'(3);
    end else begin
      it.op  = OP_W'($urandom_range(15));
      it.now = $urandom;
    end
    return it;
  endfunction

  // Present one item, hold it until taken, then note it
  task automatic send(input cmd_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= it.op;
    in_channel         <= it.ch;
    in_now             <= it.now;
    in_duration_mins   <= it.dur;
    in_alarm_hour_in   <= it.hr;
    in_alarm_minute_in <= it.mn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    @(negedge clk);
  endtask

  // Hold off until every due report is in, then let a silent tick finish
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] vmax, vmin, vled);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RUN_MAX;
    cfg_wdata <= vmax;
    @(negedge clk);
    cfg_index <= CFG_RUN_MIN;
    cfg_wdata <= vmin;
    @(negedge clk);
    cfg_index <= CFG_LED_RUN_MIN;
    cfg_wdata <= vled;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(CFG_RUN_MAX, vmax);
    board.set_reg(CFG_RUN_MIN, vmin);
    board.set_reg(CFG_LED_RUN_MIN, vled);
  endtask

  task automatic random_run(input int count, input int idle_pct, input int stall_pct);
    int k;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (k = 0; k < count; k++) send(rand_item());
    settle();
  endtask

  initial begin
    cmd_item_t opening[$];
    board = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // quiet tick, then three alarms in one window with an off and a fire on channel 0
    opening.push_back(mk(OP_TICK, 3, 32'd0, 0, 0, 0));
    opening.push_back(mk(OP_SET_ALARM, 0, 32'd0, 3, 0, 2));
    opening.push_back(mk(OP_SET_ALARM, 1, 32'd0, 0, 0, 2));
    opening.push_back(mk(OP_SET_ALARM, 2, 32'd0, 255, 0, 2));
    opening.push_back(mk(OP_ON_FOR, 0, 32'd100, 0, 0, 0));
    opening.push_back(mk(OP_TICK, 0, 32'd100, 0, 0, 0));
    opening.push_back(mk(OP_OFF_NOW, 2, 32'd110, 0, 0, 0));
    opening.push_back(mk(OP_ON_DEFAULT, 1, 32'd110, 0, 0, 0));
    opening.push_back(mk(OP_OFF_AFTER, 2, 32'hFFFF_FFFF, 255, 0, 0));
    opening.push_back(mk(OP_OFF_AFTER, 0, 32'd200, 0, 0, 0));
    // rejects: bad channel, unknown opcodes, bad alarm time
    opening.push_back(mk(OP_ON_FOR, 3, 32'd300, 5, 0, 0));
    opening.push_back(mk(4'd15, 1, 32'd300, 0, 0, 0));
    opening.push_back(mk(4'd10, 0, 32'd300, 0, 0, 0));
    opening.push_back(mk(OP_SET_ALARM, 0, 32'd300, 1, 24, 0));
    opening.push_back(mk(OP_SET_ALARM, 0, 32'd300, 1, 0, 60));
    opening.push_back(mk(OP_SET_ALARM, 3, 32'd300, 1, 31, 63));
    // midnight alarm that re-fires on the next tick
    opening.push_back(mk(OP_SET_ALARM, 1, 32'd86300, 1, 0, 0));
    opening.push_back(mk(OP_REPEAT, 1, 32'd86300, 0, 0, 0));
    opening.push_back(mk(OP_TICK, 2, 32'd86380, 0, 0, 0));
    opening.push_back(mk(OP_TICK, 1, 32'd86390, 0, 0, 0));
    opening.push_back(mk(OP_ONCE, 1, 32'd86400, 0, 0, 0));
    opening.push_back(mk(OP_DISARM, 0, 32'd86400, 0, 0, 0));
    // wrap of the 32-bit clock
    opening.push_back(mk(OP_ARM, 2, 32'hFFFF_FFFF, 0, 0, 0));
    opening.push_back(mk(OP_TICK, 0, 32'hFFFF_FFFF, 0, 0, 0));
    opening.push_back(mk(OP_ON_FOR, 2, 32'h7FFF_FFFF, 255, 23, 59));
    foreach (opening[i]) send(opening[i]);
    settle();

    configure(8'd255, 8'd0, 8'd0);
    random_run(61, 0, 0);
    configure(8'd1, 8'd255, 8'd255);
    random_run(61, 73, 0);
    configure(8'd1, 8'd0, 8'd255);
    random_run(61, 0, 73);
    configure(8'd60, 8'd5, 8'd2);
    random_run(61, 33, 33);

    board.final_check();
    if (board.fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Bound the run
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
